/* src/letter_hex_decoder_with_checksum_assert.svh */
// Assertion macros for the letter-hex decoder with checksum.
// Depends on nothing; the including module supplies aclk and aresetn.
`ifndef LETTER_HEX_DECODER_WITH_CHECKSUM_ASSERT_SVH
`define LETTER_HEX_DECODER_WITH_CHECKSUM_ASSERT_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define LHD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the next cycle.
`define LHD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LHD_ASSERT_SAME(lbl, ante, cons, msg)
`define LHD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* src/lhd_pkg.sv */
// Shared constants for the letter-hex decoder with checksum.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lhd_pkg;

    // Character codes after masking to 7 bits.
    localparam logic [6:0] CODE_TERM = 7'd124;

    // Result kinds carried on tuser.
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Final status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_NO_TERM  = 2'd2,
        ST_TRUNC    = 2'd3
    } status_t;

    // Number of checksum digits, minus one.
    localparam logic [2:0] LAST_DIGIT = 3'd7;

    // Packed widths of the stream ports.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

endpackage
`default_nettype wire

/* src/letter_hex_decoder_with_checksum.sv */
// Letter-hex decoder with checksum: stream top level.
// Depends on lhd_pkg and letter_hex_decoder_with_checksum_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "letter_hex_decoder_with_checksum_assert.svh"

// The block takes one character per item and accepts a new item every clock
// cycle while the result side keeps taking results. Each item passes through
// an input register, combinational decode logic and a result register. A result
// is presented on m_tvalid once it is loaded from the decode logic into the result
// register; a stall on the result side can hold its item in the input register first.
// Characters 64 to 79 (low 7 bits) carry nibbles, high nibble first; every
// second nibble gives a data result (tuser 0). Character 124 ends the data;
// the low nibbles of the next eight characters form the checksum, which must
// equal the byte sum plus the byte count. One status result (tuser 1) ends the
// stream; after it every item is taken and dropped until reset. While a result
// waits on the result side, the next item waits in the input register, whether
// or not it causes a result, and the input side stalls until the result is taken.
module letter_hex_decoder_with_checksum (
    input  wire                              aclk,
    input  wire                              aresetn,
    // Input channel.
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [lhd_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] char_code
    input  wire                              s_tlast,   // last_char
    // Result channel.
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [lhd_pkg::M_TDATA_W-1:0]    m_tdata,   // [7:0] data_byte, [9:8] status
    output logic                             m_tuser    // result_kind
);

    typedef enum logic [1:0] {
        PH_DATA = 2'd0,
        PH_SUM  = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    // Input register.
    logic                          in_valid_reg;
    logic [lhd_pkg::S_TDATA_W-1:0] in_code_reg;
    logic                          in_last_reg;

    // Decoder state.
    phase_t       phase_reg,   phase_next;
    logic [3:0]   held_reg,    held_next;
    logic         odd_reg,     odd_next;
    logic [31:0]  sum_reg,     sum_next;
    logic [30:0]  count_reg,   count_next;
    logic [2:0]   digit_reg,   digit_next;
    logic [31:0]  chk_reg,     chk_next;

    // Result register.
    logic              out_valid_reg;
    logic              kind_reg,   kind_next;
    logic [7:0]        byte_reg,   byte_next;
    lhd_pkg::status_t  status_reg, status_next;

    logic        advance;
    logic        out_load;
    logic [6:0]  code7;
    logic        is_nibble;
    logic [31:0] expect_sum;
    logic        status_load;
    logic        data_load;

    // The input register moves on whenever the result slot is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign code7      = in_code_reg[6:0];
    assign is_nibble  = (code7[6:4] == 3'b100);
    assign expect_sum = sum_reg + {1'b0, count_reg};

    // Decode one character against the current state.
    always_comb begin
        phase_next  = phase_reg;
        held_next   = held_reg;
        odd_next    = odd_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        digit_next  = digit_reg;
        chk_next    = chk_reg;
        out_load    = 1'b0;
        kind_next   = lhd_pkg::KIND_STATUS;
        byte_next   = 8'd0;
        status_next = lhd_pkg::ST_OK;
        if (advance) begin
            unique case (phase_reg)
                PH_DATA: begin
                    if (code7 == lhd_pkg::CODE_TERM) begin
                        phase_next = PH_SUM;
                        if (in_last_reg) begin
                            phase_next  = PH_DONE;
                            out_load    = 1'b1;
                            status_next = lhd_pkg::ST_TRUNC;
                        end
                    end else if (in_last_reg) begin
                        phase_next  = PH_DONE;
                        out_load    = 1'b1;
                        status_next = lhd_pkg::ST_NO_TERM;
                    end else if (is_nibble) begin
                        if (!odd_reg) begin
                            held_next = code7[3:0];
                            odd_next  = 1'b1;
                        end else begin
                            held_next  = 4'd0;
                            odd_next   = 1'b0;
                            byte_next  = {held_reg, code7[3:0]};
                            sum_next   = sum_reg + {24'd0, held_reg, code7[3:0]};
                            count_next = count_reg + 31'd1;
                            out_load   = 1'b1;
                            kind_next  = lhd_pkg::KIND_DATA;
                        end
                    end
                end
                PH_SUM: begin
                    chk_next = {chk_reg[27:0], code7[3:0]};
                    if (digit_reg == lhd_pkg::LAST_DIGIT) begin
                        digit_next  = 3'd0;
                        phase_next  = PH_DONE;
                        out_load    = 1'b1;
                        status_next = (chk_next == expect_sum) ? lhd_pkg::ST_OK
                                                               : lhd_pkg::ST_MISMATCH;
                    end else begin
                        digit_next = digit_reg + 3'd1;
                        if (in_last_reg) begin
                            phase_next  = PH_DONE;
                            out_load    = 1'b1;
                            status_next = lhd_pkg::ST_TRUNC;
                        end
                    end
                end
                PH_DONE: begin
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    // Control state and input valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_DATA;
            held_reg      <= 4'd0;
            odd_reg       <= 1'b0;
            sum_reg       <= 32'd0;
            count_reg     <= 31'd0;
            digit_reg     <= 3'd0;
            chk_reg       <= 32'd0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            phase_reg <= phase_next;
            held_reg  <= held_next;
            odd_reg   <= odd_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            digit_reg <= digit_next;
            chk_reg   <= chk_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_code_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (out_load) begin
            kind_reg   <= kind_next;
            byte_reg   <= byte_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {6'd0, status_reg, byte_reg};

    // Result loads split by kind, for the checks below.
    assign status_load = out_load && (kind_next == lhd_pkg::KIND_STATUS);
    assign data_load   = out_load && (kind_next == lhd_pkg::KIND_DATA);

    // Checks on the decoder's own sequencing.
    `LHD_ASSERT_SAME(a_no_result_after_done, phase_reg == PH_DONE, !out_load, "late result")
    `LHD_ASSERT_NEXT(a_status_ends_stream, status_load, phase_reg == PH_DONE, "status not final")
    `LHD_ASSERT_SAME(a_byte_needs_held, data_load, phase_reg == PH_DATA && odd_reg, "no nibble")
    `LHD_ASSERT_SAME(a_no_overwrite, out_load, !out_valid_reg || m_tready, "result overwritten")

endmodule
`default_nettype wire

/* bench/letter_hex_decoder_with_checksum_tb.sv */
// Self-checking testbench for the letter-hex decoder with checksum.
// Depends on lhd_pkg and the letter_hex_decoder_with_checksum top level.
`timescale 1ns / 1ps

module letter_hex_decoder_with_checksum_tb;

    // Nibble-carrying characters after masking to 7 bits.
    localparam logic [6:0] NIB_LO = 7'd64;
    localparam logic [6:0] NIB_HI = 7'd79;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_CHARS = 2000;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_DIGITS,
        PH_DONE
    } decode_phase_t;

    typedef enum int {
        END_GOOD,
        END_BAD_SUM,
        END_NO_TERM,
        END_TERM_LAST,
        END_SHORT_SUM,
        END_GOOD_OPEN
    } stream_end_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } char_item_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        data_byte;
        lhd_pkg::status_t  status;
    } dec_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    wire                           s_tready;
    logic [lhd_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          s_tlast = 1'b0;
    wire                           m_tvalid;
    logic                          m_tready = 1'b0;
    wire  [lhd_pkg::M_TDATA_W-1:0] m_tdata;
    wire                           m_tuser;

    letter_hex_decoder_with_checksum dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] char_code
        .s_tlast  (s_tlast),   // last_char
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] data_byte, [9:8] status
        .m_tuser  (m_tuser)    // result_kind
    );

    always #4 aclk = ~aclk;

    char_item_t  pending_chars[$];
    dec_result_t expected_results[$];
    char_item_t  drive_item;
    dec_result_t got_result;
    dec_result_t want_result;
    int          fail_count = 0;
    int          quiet_cycles = 0;
    int          send_gap = 0;
    int          send_burst = 0;
    int          recv_stall = 0;
    int          recv_burst = 0;

    // Decoder state as the block should hold it.
    decode_phase_t dec_phase;
    logic [3:0]    half_nib;
    logic          half_valid;
    logic [31:0]   byte_sum;
    logic [30:0]   byte_total;
    logic [2:0]    digits_seen;
    logic [31:0]   got_sum;

    // Mostly short stalls, a few long ones.
    function automatic int draw_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A final status ends the stream; nothing follows it until reset.
    task post_status(input lhd_pkg::status_t st);
        expected_results.push_back({lhd_pkg::KIND_STATUS, 8'd0, st});
        dec_phase = PH_DONE;
    endtask

    // Advance the decoder state by one accepted character.
    task decode_char(input logic [7:0] ch, input logic fin);
        logic [6:0] code;
        logic [7:0] byte_val;
        code = ch[6:0];
        case (dec_phase)
            PH_DATA: begin
                if (code == lhd_pkg::CODE_TERM) begin
                    dec_phase = PH_DIGITS;
                    if (fin)
                        post_status(lhd_pkg::ST_TRUNC);
                end else if (fin) begin
                    post_status(lhd_pkg::ST_NO_TERM);
                end else if (code >= NIB_LO && code <= NIB_HI) begin
                    if (!half_valid) begin
                        half_nib = code[3:0];
                        half_valid = 1'b1;
                    end else begin
                        byte_val = {half_nib, code[3:0]};
                        half_nib = 4'd0;
                        half_valid = 1'b0;
                        byte_sum = byte_sum + {24'd0, byte_val};
                        byte_total = byte_total + 31'd1;
                        expected_results.push_back({lhd_pkg::KIND_DATA, byte_val,
                                                    lhd_pkg::ST_OK});
                    end
                end
            end
            PH_DIGITS: begin
                got_sum = {got_sum[27:0], code[3:0]};
                if (digits_seen == lhd_pkg::LAST_DIGIT) begin
                    digits_seen = 3'd0;
                    if (got_sum == byte_sum + {1'b0, byte_total})
                        post_status(lhd_pkg::ST_OK);
                    else
                        post_status(lhd_pkg::ST_MISMATCH);
                end else begin
                    digits_seen = digits_seen + 3'd1;
                    if (fin)
                        post_status(lhd_pkg::ST_TRUNC);
                end
            end
            default: ;
        endcase
    endtask

    // Input side: one item at a time from the pending queue, with random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            dec_phase = PH_DATA;
            half_nib = 4'd0;
            half_valid = 1'b0;
            byte_sum = 32'd0;
            byte_total = 31'd0;
            digits_seen = 3'd0;
            got_sum = 32'd0;
        end else begin
            if (s_tvalid && s_tready)
                decode_char(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_chars.size() > 0) begin
                    drive_item = pending_chars.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= drive_item.ch;
                    s_tlast <= drive_item.fin;
                    if (send_burst > 0)
                        send_burst--;
                    else if ($urandom_range(0, 299) == 0)
                        send_burst = $urandom_range(40, 200);
                    else if ($urandom_range(0, 2) == 0)
                        send_gap = draw_stall();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: random back pressure and a field-by-field compare.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_result = {m_tuser, m_tdata[7:0], lhd_pkg::status_t'(m_tdata[9:8])};
                if (expected_results.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: unexpected result kind %0d byte %02h status %0d",
                                 $realtime, got_result.kind, got_result.data_byte,
                                 got_result.status);
                    fail_count++;
                end else begin
                    want_result = expected_results.pop_front();
                    if (got_result.kind !== want_result.kind
                            || got_result.data_byte !== want_result.data_byte
                            || got_result.status !== want_result.status) begin
                        if (fail_count < MAX_REPORTS)
                            $display({"%0t: result mismatch: expected kind %0d byte %02h ",
                                      "status %0d, got kind %0d byte %02h status %0d"},
                                     $realtime, want_result.kind, want_result.data_byte,
                                     want_result.status, got_result.kind,
                                     got_result.data_byte, got_result.status);
                        fail_count++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (recv_burst > 0)
                    recv_burst--;
                else if ($urandom_range(0, 299) == 0)
                    recv_burst = $urandom_range(40, 200);
                else if ($urandom_range(0, 7) == 0)
                    recv_stall = draw_stall();
            end
        end
    end

    // Watchdog: too long without any item moving on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task queue_char(input logic [7:0] ch, input logic fin);
        pending_chars.push_back({ch, fin});
    endtask

    // Nibble character, sometimes with the ignored top bit set.
    function automatic logic [7:0] nib_char(input logic [3:0] n);
        logic [7:0] c;
        c = {1'b0, NIB_LO} | {4'd0, n};
        c[7] = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // Any character that the data phase ignores.
    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        c = 8'($urandom);
        while (c[6:0] == lhd_pkg::CODE_TERM || (c[6:0] >= NIB_LO && c[6:0] <= NIB_HI))
            c = 8'($urandom);
        return c;
    endfunction

    // Checksum digit: only the low four bits count.
    function automatic logic [7:0] digit_char(input logic [3:0] n);
        return {4'($urandom), n};
    endfunction

    // Hold off until the block has taken everything and returned every result.
    task drain_stream();
        while (pending_chars.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        stream_end_t finish_kind;
        logic [31:0] target;
        int          short_len;
        logic        fin_now;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: nibble extremes, masked top bit, ignored neighbors of the ranges.
        queue_char(8'h40, 1'b0);
        queue_char(8'h4F, 1'b0);
        queue_char(8'h4F, 1'b0);
        queue_char(8'h40, 1'b0);
        queue_char(8'h40, 1'b0);
        queue_char(8'h40, 1'b0);
        queue_char(8'h4F, 1'b0);
        queue_char(8'h4F, 1'b0);
        queue_char(8'hC0, 1'b0);
        queue_char(8'hCF, 1'b0);
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_char(8'h3F, 1'b0);
        queue_char(8'h50, 1'b0);
        queue_char(8'h7B, 1'b0);
        queue_char(8'h7D, 1'b0);
        queue_char(8'hD0, 1'b0);
        queue_char(8'h4A, 1'b0);
        queue_char(8'h80, 1'b0);
        queue_char(8'h45, 1'b0);
        drain_stream();

        // Random data phase: mostly nibbles, some ignored characters.
        for (int i = 0; i < RANDOM_CHARS; i++) begin
            if ($urandom_range(0, 99) < 85)
                queue_char(nib_char(4'($urandom)), 1'b0);
            else
                queue_char(noise_char(), 1'b0);
        end
        drain_stream();

        // The sum is settled now; pick how the stream ends.
        finish_kind = stream_end_t'($urandom_range(0, 5));
        target = byte_sum + {1'b0, byte_total};
        case (finish_kind)
            END_GOOD, END_BAD_SUM, END_GOOD_OPEN: begin
                if (finish_kind == END_BAD_SUM)
                    target = target ^ (32'd1 << $urandom_range(0, 31));
                queue_char({$urandom_range(0, 1) ? 1'b1 : 1'b0, lhd_pkg::CODE_TERM}, 1'b0);
                fin_now = (finish_kind == END_GOOD)
                          || (finish_kind == END_BAD_SUM && $urandom_range(0, 1));
                for (int d = 7; d >= 0; d--)
                    queue_char(digit_char(target[d*4 +: 4]), d == 0 ? fin_now : 1'b0);
            end
            END_NO_TERM: begin
                // Usually the final character would have completed a byte.
                if (!half_valid && $urandom_range(0, 3) != 0)
                    queue_char(nib_char(4'($urandom)), 1'b0);
                if ($urandom_range(0, 9) < 7)
                    queue_char(nib_char(4'($urandom)), 1'b1);
                else
                    queue_char(noise_char(), 1'b1);
            end
            END_TERM_LAST: begin
                queue_char({1'b1, lhd_pkg::CODE_TERM}, 1'b1);
            end
            default: begin
                short_len = $urandom_range(1, 7);
                queue_char({1'b0, lhd_pkg::CODE_TERM}, 1'b0);
                for (int d = 1; d <= short_len; d++)
                    queue_char(8'($urandom), d == short_len);
            end
        endcase

        // After the final status every item is dropped.
        for (int i = 0; i < 20; i++)
            queue_char(8'($urandom), 1'($urandom_range(0, 1)));
        drain_stream();
        repeat (10) @(posedge aclk);

        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $realtime,
                     expected_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/lhd_pkg.sv
src/letter_hex_decoder_with_checksum.sv
bench/letter_hex_decoder_with_checksum_tb.sv
